>>> hdl/satl_pkg.sv
// ----------------------------------------------------------------------------
// satl_pkg: shared types and constants of the set-associative tag store
// Geometry, state width, operation codes and the beat passed from the front
// part to the back part.
// ----------------------------------------------------------------------------
package satl_pkg;

    localparam int SETS     = 64;
    localparam int WAYS     = 4;
    localparam int TAG_BITS = 32;

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W  = SET_W + WAY_W;
    localparam int DEPTH  = SETS * WAYS;
    localparam int STATE_W = 3;
    localparam int MASK_W  = 8;

    localparam logic [MASK_W-1:0] DIRTY_MASK_RESET = 8'd24;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_CHANGE = 2'd1,
        OP_TOUCH  = 2'd2,
        OP_INSERT = 2'd3
    } op_t;

    // One operation as decoded by the front part.
    typedef struct packed {
        op_t                 op;
        logic [SET_W-1:0]    set_idx;
        logic [TAG_BITS-1:0] tag;
        logic [STATE_W-1:0]  new_state;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [STATE_W-1:0]  line_state;
        logic [TAG_BITS-1:0] victim_tag;
        logic                writeback_needed;
    } rsp_t;

endpackage

>>> hdl/set_assoc_tag_store_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_tag_store_lru: tag and state array with true LRU replacement
// Lookup, change state, touch and insert on a set-associative tag store.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      mode, set_index, tag, new_state
//  result    empty / pop      hit, line_state, victim_tag, writeback_needed
//  config    dirty_state_wr   dirty_state_mask
//
// An operation that changes anything goes through these steps: the beat is taken,
// the ways of the set are read one per cycle from the single-port entry memory,
// the last read is collected, a write pass stores every way of the set, and the
// result is presented until it is popped. An operation that changes nothing
// skips the write pass.
// After reset a clearing pass over all SETS*WAYS entries (256) loads each way with
// its own number as tag, invalid state and rank equal to way; push is held
// off meanwhile, apart from the two beats the input queue can hold.
// The input queue keeps taking beats while the back part works or while a
// result beat waits to be popped.
// ----------------------------------------------------------------------------
module set_assoc_tag_store_lru
    import satl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [5:0]  set_index,
    input  logic [31:0] tag,
    input  logic [2:0]  new_state,
    output logic        empty,
    input  logic        pop,
    output logic        hit,
    output logic [2:0]  line_state,
    output logic [31:0] victim_tag,
    output logic        writeback_needed,
    input  logic        dirty_state_wr,
    input  logic [7:0]  dirty_state_mask
);

    logic               req_valid;
    logic               req_take;
    req_t               req;
    logic               rsp_valid;
    rsp_t               rsp;
    logic [MASK_W-1:0]  mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= DIRTY_MASK_RESET;
        end
        else if (dirty_state_wr)
        begin
            mask_reg <= dirty_state_mask;
        end
    end

    satl_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .set_index (set_index),
        .tag       (tag),
        .new_state (new_state),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req)
    );

    satl_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_take   (req_take),
        .req        (req),
        .dirty_mask (mask_reg),
        .rsp_valid  (rsp_valid),
        .rsp_take   (pop),
        .rsp        (rsp)
    );

    // The result register in the back part holds the beat until it is popped.
    assign empty            = !rsp_valid;
    assign hit              = rsp.hit;
    assign line_state       = rsp.line_state;
    assign victim_tag       = 32'(rsp.victim_tag);
    assign writeback_needed = rsp.writeback_needed;

endmodule

>>> hdl/satl_front.sv
// ----------------------------------------------------------------------------
// satl_front: input queue
// Accepts beats, reduces the set index and tag, and holds them in a short
// queue until the back part takes them.
// ----------------------------------------------------------------------------
module satl_front
    import satl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          mode,
    input  logic [5:0]          set_index,
    input  logic [31:0]         tag,
    input  logic [2:0]          new_state,
    output logic                req_valid,
    input  logic                req_take,
    output req_t                req
);

    localparam int QD = 2;

    req_t     q_reg [QD];
    logic     wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t     in_req;
    logic     do_push, do_pop;
    logic [5:0] set_mod;
    logic [31:0] tag_m;

    always_comb
    begin
        set_mod = 6'({1'b0, set_index} % 7'(SETS));
        tag_m   = tag & 32'((64'd1 << TAG_BITS) - 64'd1);
        in_req.op        = op_t'(mode);
        in_req.set_idx   = set_mod[SET_W-1:0];
        in_req.tag       = TAG_BITS'(tag_m);
        in_req.new_state = new_state;
    end

    assign full      = (cnt_reg == 2'(QD));
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_valid && req_take;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hdl/satl_back.sv
// ----------------------------------------------------------------------------
// satl_back: tag array sequencer
// Reads the ways of a set one per cycle from the memory, then, if anything changes,
// writes back the changed tag, state and ranks, and hands a result beat onwards.
// Reset is followed by a clearing pass over every entry.
// ----------------------------------------------------------------------------
module satl_back
    import satl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_take,
    input  req_t                req,
    input  logic [MASK_W-1:0]   dirty_mask,
    output logic                rsp_valid,
    input  logic                rsp_take,
    output rsp_t                rsp
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_OUT   = 6'b100000
    } st_t;

    // One memory word per entry: tag, state and rank of one way.
    localparam int WORD_W = TAG_BITS + STATE_W + WAY_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_reg;

    st_t               st_reg, st_next;
    logic [ENT_W:0]    clr_reg;
    logic [WAY_W:0]    rcnt_reg;   // ways issued
    logic [WAY_W:0]    ccnt_reg;   // ways captured
    logic              rd_vld_reg;
    logic [WAY_W:0]    wcnt_reg;
    req_t              cur_reg;

    logic [TAG_BITS-1:0] tags_reg  [WAYS];
    logic [STATE_W-1:0]  sts_reg   [WAYS];
    logic [WAY_W-1:0]    ranks_reg [WAYS];

    logic                hit_reg;
    logic [WAY_W-1:0]    hway_reg;
    logic [WAY_W-1:0]    lru_reg;
    rsp_t                rsp_reg;

    logic [TAG_BITS-1:0] r_tag;
    logic [STATE_W-1:0]  r_st;
    logic [WAY_W-1:0]    r_rank;
    logic [WAY_W-1:0]    cway;

    // Target way, its old rank, and what the write pass stores.
    logic                upd;
    logic [WAY_W-1:0]    tway;
    logic [WAY_W-1:0]    trank;
    logic [WAY_W-1:0]    wway;
    logic [TAG_BITS-1:0] w_tag;
    logic [STATE_W-1:0]  w_st;
    logic [WAY_W-1:0]    w_rank;
    logic                wr_en;
    logic [ENT_W-1:0]    wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [ENT_W-1:0]    rd_addr;
    logic                rd_en;

    assign {r_tag, r_st, r_rank} = rd_reg;
    assign cway = ccnt_reg[WAY_W-1:0];

    assign req_take  = (st_reg == ST_IDLE) && req_valid;
    assign rsp_valid = (st_reg == ST_OUT);
    assign rsp       = rsp_reg;

    always_comb
    begin
        upd   = 1'b0;
        tway  = hway_reg;
        unique case (cur_reg.op)
            OP_LOOKUP: upd = 1'b0;
            OP_CHANGE: upd = hit_reg;
            OP_TOUCH:  upd = hit_reg;
            OP_INSERT:
            begin
                upd  = 1'b1;
                tway = hit_reg ? hway_reg : lru_reg;
            end
            default:   upd = 1'b0;
        endcase
        trank  = ranks_reg[tway];
        wway   = wcnt_reg[WAY_W-1:0];
        w_tag  = tags_reg[wway];
        w_st   = sts_reg[wway];
        w_rank = ranks_reg[wway];
        if (cur_reg.op != OP_CHANGE)
        begin
            if (wway == tway)
            begin
                w_rank = WAY_W'(WAYS - 1);
            end
            else if (w_rank > trank)
            begin
                w_rank = w_rank - 1'b1;
            end
        end
        if (wway == tway && cur_reg.op != OP_TOUCH)
        begin
            w_st = cur_reg.new_state;
            if (cur_reg.op == OP_INSERT)
            begin
                w_tag = cur_reg.tag;
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {cur_reg.set_idx, wway};
        wr_data = {w_tag, w_st, w_rank};
        if (st_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[ENT_W-1:0];
            wr_data = {TAG_BITS'(clr_reg[WAY_W-1:0]), STATE_W'(0),
                       clr_reg[WAY_W-1:0]};
        end
        else if (st_reg == ST_WRITE)
        begin
            wr_en = 1'b1;
        end
        rd_en   = (st_reg == ST_READ);
        rd_addr = {cur_reg.set_idx, rcnt_reg[WAY_W-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR: if (clr_reg == (ENT_W+1)'(DEPTH - 1)) st_next = ST_IDLE;
            ST_IDLE:  if (req_valid) st_next = ST_READ;
            ST_READ:  if (rcnt_reg == (WAY_W+1)'(WAYS - 1)) st_next = ST_WAIT;
            ST_WAIT:  if (!rd_vld_reg && ccnt_reg == (WAY_W+1)'(WAYS))
                          st_next = upd ? ST_WRITE : ST_OUT;
            ST_WRITE: if (wcnt_reg == (WAY_W+1)'(WAYS - 1)) st_next = ST_OUT;
            ST_OUT:   if (rsp_take) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && req_valid)
        begin
            cur_reg <= req;
            hit_reg <= 1'b0;
            hway_reg <= '0;
            lru_reg <= '0;
        end
        if (rd_vld_reg)
        begin
            tags_reg[cway]  <= r_tag;
            sts_reg[cway]   <= r_st;
            ranks_reg[cway] <= r_rank;
            // First matching way wins, as the ways are captured in order.
            if (r_tag == cur_reg.tag && !hit_reg)
            begin
                hit_reg  <= 1'b1;
                hway_reg <= cway;
            end
            if (r_rank == '0)
            begin
                lru_reg <= cway;
            end
        end
        if (st_reg == ST_WAIT && st_next != ST_WAIT)
        begin
            rsp_reg.hit              <= hit_reg;
            rsp_reg.line_state       <= hit_reg ? sts_reg[hway_reg] : '0;
            rsp_reg.victim_tag       <= '0;
            rsp_reg.writeback_needed <= 1'b0;
            if (cur_reg.op == OP_INSERT && !hit_reg)
            begin
                rsp_reg.victim_tag       <= tags_reg[lru_reg];
                rsp_reg.writeback_needed <= dirty_mask[sts_reg[lru_reg]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_CLEAR;
            clr_reg    <= '0;
            rcnt_reg   <= '0;
            ccnt_reg   <= '0;
            wcnt_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            rd_vld_reg <= rd_en;
            if (st_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (st_reg == ST_IDLE)
            begin
                rcnt_reg <= '0;
                ccnt_reg <= '0;
                wcnt_reg <= '0;
            end
            if (rd_en)
            begin
                rcnt_reg <= rcnt_reg + 1'b1;
            end
            if (rd_vld_reg)
            begin
                ccnt_reg <= ccnt_reg + 1'b1;
            end
            if (st_reg == ST_WRITE)
            begin
                wcnt_reg <= wcnt_reg + 1'b1;
            end
        end
    end

endmodule
